[rtl/dts_pkg.sv]
// dts_pkg: shared types, states and functions of the token scanner
`timescale 1ns / 1ps
package dts_pkg;

  localparam int KwMaxLen  = 6;
  localparam int LengthMax = 255;
  localparam int FifoDepth = 4;

  localparam logic [5:0] K_NUM      = 6'd9;
  localparam logic [5:0] K_CHARLIT  = 6'd10;
  localparam logic [5:0] K_ID       = 6'd11;
  localparam logic [5:0] S_START    = 6'd59;
  localparam logic [5:0] S_APOS     = 6'd60;
  localparam logic [5:0] S_APOSLASH = 6'd61;
  localparam logic [5:0] S_NOTCHAR  = 6'd62;
  localparam logic [5:0] S_NONE     = 6'd63;

  localparam logic [30:0] NumMax = 31'h7fff_ffff;

  typedef struct packed {
    logic [5:0]             state;
    logic [KwMaxLen-1:0][6:0] chars;
    logic [7:0]             len;
    logic [30:0]            accum;
    logic                   ovf;
  } lex_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  kind;
    logic [7:0]  length;
    logic [30:0] value;
    logic [31:0] line;
    logic        last;
  } res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0a || c == 8'h09 || c == 8'h0b || c == 8'h0d;
  endfunction

  function automatic logic [5:0] start_state(input logic [7:0] c);
    logic [5:0] r;
    r = S_NONE;
    unique case (c)
      ":": r = 6'd21;  "(": r = 6'd22;  ")": r = 6'd23;  ";": r = 6'd24;
      "{": r = 6'd25;  "}": r = 6'd26;  ",": r = 6'd27;  "[": r = 6'd28;
      "]": r = 6'd29;  "=": r = 6'd30;  "!": r = 6'd31;  ">": r = 6'd35;
      "<": r = 6'd37;  "+": r = 6'd40;  "-": r = 6'd41;  "*": r = 6'd42;
      "@": r = 6'd43;  "$": r = 6'd44;  "/": r = 6'd45;  "%": r = 6'd46;
      "|": r = 6'd50;  "^": r = 6'd51;  "&": r = 6'd52;  "~": r = 6'd53;
      ".": r = 6'd57;  8'h27: r = S_APOS;
      default: r = S_NONE;
    endcase
    if (is_alpha(c)) r = K_ID;
    if (is_digit(c)) r = K_NUM;
    return r;
  endfunction

  function automatic logic [5:0] next_state(input logic [5:0] s, input logic [7:0] c);
    logic [5:0] r;
    r = S_NONE;
    priority case (s)
      S_START: r = start_state(c);
      K_ID:    r = (is_alpha(c) || is_digit(c)) ? K_ID : S_NONE;
      K_NUM:   r = is_digit(c) ? K_NUM : S_NONE;
      6'd30:   r = (c == "=") ? 6'd38 : S_NONE;
      6'd31:   r = (c == "=") ? 6'd39 : S_NONE;
      6'd50:   r = (c == "|") ? 6'd32 : S_NONE;
      6'd52:   r = (c == "&") ? 6'd33 : S_NONE;
      6'd35:   r = (c == "=") ? 6'd34 : ((c == ">") ? 6'd48 : S_NONE);
      6'd37:   r = (c == "=") ? 6'd36 : ((c == "<") ? 6'd47 : S_NONE);
      6'd40:   r = (c == "+") ? 6'd54 : S_NONE;
      6'd51:   r = (c == "^") ? 6'd49 : S_NONE;
      6'd41:   r = (c == "-") ? 6'd55 : ((c == ">") ? 6'd56 : S_NONE);
      S_APOS: begin
        if (c == 8'h5c) r = S_APOSLASH;
        else if (c == 8'h22 || c == 8'h27 || c == "?") r = S_NONE;
        else r = (c >= 8'h20 && c <= 8'h7e) ? S_NOTCHAR : S_NONE;
      end
      S_APOSLASH: begin
        if (c == 8'h5c || c == 8'h22 || c == 8'h27 || c == "?" || c == "n" ||
            c == "t" || c == "r" || c == "b" || c == "a" || c == "0" ||
            c == "f" || c == "v") r = S_NOTCHAR;
      end
      S_NOTCHAR: r = (c == 8'h27) ? K_CHARLIT : S_NONE;
      default: r = S_NONE;
    endcase
    if (c[7]) r = S_NONE;
    return r;
  endfunction

  // keyword text zero-padded to six characters, lowest byte first
  function automatic logic [5:0] keyword_kind(input logic [KwMaxLen-1:0][6:0] ch,
                                              input logic [7:0] len);
    logic [47:0] w;
    logic [5:0]  k;
    w = '0;
    for (int i = 0; i < KwMaxLen; i++) w[8*i +: 8] = {1'b0, ch[i]};
    k = K_ID;
    unique case (w)
      {16'h0, "niam"}:   k = 6'd0;
      {16'h0, "daer"}:   k = 6'd1;
      {8'h0, "tnirp"}:   k = 6'd2;
      {24'h0, "tni"}:    k = 6'd3;
      {16'h0, "rahc"}:   k = 6'd4;
      {16'h0, "loob"}:   k = 6'd5;
      "tcurts":          k = 6'd58;
      {16'h0, "eurt"}:   k = 6'd6;
      {8'h0, "eslaf"}:   k = 6'd7;
      {16'h0, "LLUN"}:   k = 6'd8;
      "nruter":          k = 6'd12;
      {32'h0, "fi"}:     k = 6'd13;
      {16'h0, "file"}:   k = 6'd14;
      {16'h0, "esle"}:   k = 6'd15;
      {24'h0, "rof"}:    k = 6'd16;
      {8'h0, "elihw"}:   k = 6'd17;
      {8'h0, "kaerb"}:   k = 6'd18;
      "eteled":          k = 6'd19;
      {24'h0, "wen"}:    k = 6'd20;
      default:           k = K_ID;
    endcase
    if (len > 8'(KwMaxLen)) k = K_ID;
    return k;
  endfunction

endpackage

[rtl/dfa_token_scanner_unit.sv]
// dfa_token_scanner_unit: top level of the byte-stream lexer
//
// channel  dir  tdata                                   tuser     tlast
// s_*      in   [7:0] text_byte                         -         end_of_text
// m_*      out  kind, length, number_value, line_number status    last_of_run
//
// one byte per cycle while the queue has room: input register, then transition
// logic into a four-entry result queue, from whose registers a result is offered.
// bytes move on while the queue holds two or fewer; with a ready sink only bytes
// causing two results grow a non-empty queue, and input stalls while three or more wait.
// rst clears the automaton, sets the line to one and empties the queue.
`timescale 1ns / 1ps
module dfa_token_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // token_kind, token_length, number_value, line_number, zeros
  output logic        m_tuser,   // status
  output logic        m_tlast    // last_of_run
);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          in_end;
  logic          go, room;
  logic [1:0]    res_count;
  logic [2:0]    count;
  dts_pkg::res_t res0, res1, head;

  assign go       = in_valid && room;
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) in_valid <= 1'b0;
    else if (s_tready) in_valid <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_end <= s_tlast;
    end
  end

  dts_core u_core (
    .clk(clk), .rst(rst), .go(go), .text_byte(in_byte), .end_of_text(in_end),
    .res_count(res_count), .res0(res0), .res1(res1)
  );

  dts_fifo u_fifo (
    .clk(clk), .rst(rst), .push_count(res_count), .push0(res0), .push1(res1),
    .pop(m_tready), .not_empty(m_tvalid), .room_for_two(room), .head(head),
    .count(count)
  );

  assign m_tdata = {3'b000, head.line, head.value, head.length, head.kind};
  assign m_tuser = head.status;
  assign m_tlast = head.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(dts_pkg::FifoDepth)) else $error("result queue overfilled");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |=> !(m_tvalid && !m_tuser)) else $error("token after error");

  a_go_room: assert property (@(posedge clk) disable iff (rst)
    res_count != 2'd0 |-> count <= 3'd2) else $error("push without room");

endmodule

[rtl/dts_core.sv]
// dts_core: scanner state registers and the per-item transition logic
`timescale 1ns / 1ps
module dts_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [7:0]        text_byte,
  input  logic              end_of_text,
  output logic [1:0]        res_count,
  output dts_pkg::res_t     res0,
  output dts_pkg::res_t     res1
);

  dts_pkg::lex_t lex, lex_next;
  logic [31:0]   line_count, line_count_next;
  logic          in_comment, in_comment_next;
  logic          halted, halted_next;

  function automatic dts_pkg::lex_t clear_lex();
    dts_pkg::lex_t l;
    l = '0;
    l.state = dts_pkg::S_START;
    return l;
  endfunction

  function automatic dts_pkg::lex_t advance(input dts_pkg::lex_t l, input logic [5:0] nx,
                                            input logic [7:0] c);
    dts_pkg::lex_t o;
    logic [34:0]   v;
    o = l;
    for (int i = 0; i < dts_pkg::KwMaxLen; i++)
      if (l.len == 8'(i)) o.chars[i] = c[6:0];
    if (l.len < 8'(dts_pkg::LengthMax)) o.len = l.len + 8'd1;
    v = 35'(l.accum) * 35'd10 + 35'(c - "0");
    if (nx == dts_pkg::K_NUM && !l.ovf) begin
      if (v > 35'(dts_pkg::NumMax)) o.ovf = 1'b1;
      else o.accum = v[30:0];
    end
    o.state = nx;
    return o;
  endfunction

  function automatic logic finish_bad(input dts_pkg::lex_t l);
    return l.state >= dts_pkg::S_START ||
           (l.state == dts_pkg::K_NUM &&
            (l.ovf || (l.chars[0] == 7'h30 && l.len > 8'd1)));
  endfunction

  function automatic dts_pkg::res_t make_res(input logic err, input dts_pkg::lex_t l,
                                             input logic [31:0] line);
    dts_pkg::res_t r;
    r = '0;
    r.line = line;
    r.status = err;
    if (!err) begin
      r.kind = (l.state == dts_pkg::K_ID) ? dts_pkg::keyword_kind(l.chars, l.len) : l.state;
      r.length = l.len;
      r.value = (l.state == dts_pkg::K_NUM) ? l.accum : '0;
    end
    return r;
  endfunction

  always_comb begin
    dts_pkg::res_t r [2];
    logic [1:0]    n;
    logic [5:0]    nx;
    logic          bad;
    r[0] = '0;
    r[1] = '0;
    n = '0;
    nx = dts_pkg::S_NONE;
    bad = 1'b0;
    lex_next = lex;
    halted_next = halted;
    in_comment_next = in_comment;
    line_count_next = line_count;
    if (halted) begin
      r[0] = make_res(1'b1, lex, line_count);
      n = 2'd1;
    end else if (in_comment) begin
      if (text_byte == 8'h0a) in_comment_next = 1'b0;
    end else if (text_byte == "#") begin
      if (lex.state != dts_pkg::S_START) begin
        bad = finish_bad(lex);
        r[0] = make_res(bad, lex, line_count);
        n = 2'd1;
        if (bad) halted_next = 1'b1;
        else lex_next = clear_lex();
      end
      if (!halted_next) in_comment_next = 1'b1;
    end else begin
      nx = dts_pkg::next_state(lex.state, text_byte);
      if (nx != dts_pkg::S_NONE) begin
        lex_next = advance(lex, nx, text_byte);
      end else if (lex.state == dts_pkg::S_START) begin
        if (!dts_pkg::is_space(text_byte)) begin
          r[0] = make_res(1'b1, lex, line_count);
          n = 2'd1;
          halted_next = 1'b1;
        end
      end else begin
        bad = finish_bad(lex);
        r[0] = make_res(bad, lex, line_count);
        n = 2'd1;
        if (bad) begin
          halted_next = 1'b1;
        end else begin
          nx = dts_pkg::next_state(dts_pkg::S_START, text_byte);
          if (nx != dts_pkg::S_NONE) begin
            lex_next = advance(clear_lex(), nx, text_byte);
          end else begin
            lex_next = clear_lex();
            if (!dts_pkg::is_space(text_byte)) begin
              r[1] = make_res(1'b1, lex, line_count);
              n = 2'd2;
              halted_next = 1'b1;
            end
          end
        end
      end
    end
    if (!halted_next && end_of_text && lex_next.state != dts_pkg::S_START) begin
      bad = finish_bad(lex_next);
      r[n[0]] = make_res(bad, lex_next, line_count);
      n = n + 2'd1;
      if (bad) halted_next = 1'b1;
      else lex_next = clear_lex();
    end
    if (!halted_next) begin
      if (text_byte == 8'h0a && line_count != '1) line_count_next = line_count + 32'd1;
      if (end_of_text) begin
        in_comment_next = 1'b0;
        line_count_next = 32'd1;
      end
    end
    if (halted) begin
      halted_next = 1'b1;
      in_comment_next = in_comment;
      line_count_next = line_count;
    end
    r[0].last = (n == 2'd1);
    r[1].last = (n == 2'd2);
    res0 = r[0];
    res1 = r[1];
    res_count = go ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex <= clear_lex();
      line_count <= 32'd1;
      in_comment <= 1'b0;
      halted <= 1'b0;
    end else if (go) begin
      lex <= lex_next;
      line_count <= line_count_next;
      in_comment <= in_comment_next;
      halted <= halted_next;
    end
  end

endmodule

[rtl/dts_fifo.sv]
// dts_fifo: four-entry result queue taking up to two results per cycle
`timescale 1ns / 1ps
module dts_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_count,
  input  dts_pkg::res_t push0,
  input  dts_pkg::res_t push1,
  input  logic          pop,
  output logic          not_empty,
  output logic          room_for_two,
  output dts_pkg::res_t head,
  output logic [2:0]    count
);

  dts_pkg::res_t entries [dts_pkg::FifoDepth];
  logic [1:0] wr_ptr, rd_ptr;
  logic       do_pop;

  assign not_empty    = count != 3'd0;
  assign room_for_two = count <= 3'd2;
  assign head         = entries[rd_ptr];
  assign do_pop       = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push0;
    if (push_count == 2'd2) entries[wr_ptr + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + 2'(do_pop);
      count <= count + 3'(push_count) - 3'(do_pop);
    end
  end

endmodule

[verif/dfa_token_scanner_unit_tb.sv]
// dfa_token_scanner_unit_tb: self-checking stream testbench for the token scanner
`timescale 1ns / 1ps
module dfa_token_scanner_unit_tb;

  typedef struct {
    bit        status;
    bit [5:0]  kind;
    bit [7:0]  length;
    bit [30:0] value;
    bit [31:0] line;
    bit        last;
  } token_t;

  localparam int LenSat = 255;
  localparam int KwLen  = 6;

  class token_scoreboard;
    token_t    pending[$];
    int        errors;
    bit [5:0]  state;
    byte       kw_text[KwLen];
    int        lex_len;
    longint    accum;
    bit        ovf;
    bit [31:0] line;
    bit        in_comment;
    bit        halted;
    token_t    step_out[$];
    string     kw_names[19] = '{"main", "read", "print", "int", "char", "bool", "struct",
                                "true", "false", "NULL", "return", "if", "elif", "else",
                                "for", "while", "break", "delete", "new"};
    int        kw_kinds[19] = '{0, 1, 2, 3, 4, 5, 58, 6, 7, 8, 12, 13, 14, 15, 16, 17, 18,
                                19, 20};
    string     start_chars = ":(),;{}[]=!><+-*@$/%|^&~.";
    int        start_kinds[25] = '{21, 22, 23, 27, 24, 25, 26, 28, 29, 30, 31, 35, 37, 40,
                                   41, 42, 43, 44, 45, 46, 50, 51, 52, 53, 57};
    // pairs: first kind, second byte, joined kind
    int        pair_from[12]  = '{30, 31, 50, 52, 35, 35, 37, 37, 40, 51, 41, 41};
    byte       pair_char[12]  = '{"=", "=", "|", "&", "=", ">", "=", "<", "+", "^", "-", ">"};
    int        pair_to[12]    = '{38, 39, 32, 33, 34, 48, 36, 47, 54, 49, 55, 56};

    function new();
      errors = 0;
      line = 1;
      in_comment = 0;
      halted = 0;
      clear_lexeme();
    endfunction

    function void clear_lexeme();
      state = dts_pkg::S_START;
      foreach (kw_text[i]) kw_text[i] = 0;
      lex_len = 0;
      accum = 0;
      ovf = 0;
    endfunction

    function bit alpha(byte unsigned c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit [5:0] advance_state(bit [5:0] s, byte unsigned c);
      bit dig;
      dig = c >= "0" && c <= "9";
      if (c >= 128) return dts_pkg::S_NONE;
      if (s == dts_pkg::S_START) begin
        if (alpha(c)) return dts_pkg::K_ID;
        if (dig) return dts_pkg::K_NUM;
        if (c == 8'h27) return dts_pkg::S_APOS;
        for (int i = 0; i < start_chars.len(); i++)
          if (start_chars[i] == c) return 6'(start_kinds[i]);
        return dts_pkg::S_NONE;
      end
      if (s == dts_pkg::K_ID) return (alpha(c) || dig) ? dts_pkg::K_ID : dts_pkg::S_NONE;
      if (s == dts_pkg::K_NUM) return dig ? dts_pkg::K_NUM : dts_pkg::S_NONE;
      if (s == dts_pkg::S_APOS) begin
        if (c == 8'h5c) return dts_pkg::S_APOSLASH;
        if (c == 8'h22 || c == 8'h27 || c == "?") return dts_pkg::S_NONE;
        return (c >= 8'h20 && c <= 8'h7e) ? dts_pkg::S_NOTCHAR : dts_pkg::S_NONE;
      end
      if (s == dts_pkg::S_APOSLASH) begin
        if (c == 8'h5c || c == 8'h22 || c == 8'h27 || c == "?" || c == "n" || c == "t" ||
            c == "r" || c == "b" || c == "a" || c == "0" || c == "f" || c == "v")
          return dts_pkg::S_NOTCHAR;
        return dts_pkg::S_NONE;
      end
      if (s == dts_pkg::S_NOTCHAR)
        return (c == 8'h27) ? dts_pkg::K_CHARLIT : dts_pkg::S_NONE;
      for (int i = 0; i < 12; i++)
        if (pair_from[i] == s && pair_char[i] == c) return 6'(pair_to[i]);
      return dts_pkg::S_NONE;
    endfunction

    function void emit(bit st, bit [5:0] kind, bit [7:0] len, bit [30:0] val);
      token_t t;
      t.status = st;
      t.kind = kind;
      t.length = len;
      t.value = val;
      t.line = line;
      t.last = 0;
      step_out = {step_out, t};
    endfunction

    function void lex_error();
      emit(1, 0, 0, 0);
      halted = 1;
    endfunction

    function void close_token();
      bit [5:0] kind;
      bit [30:0] val;
      string s;
      kind = state;
      val = 0;
      if (kind >= dts_pkg::S_START) begin
        lex_error();
        return;
      end
      if (kind == dts_pkg::K_NUM) begin
        if (ovf || (kw_text[0] == "0" && lex_len > 1)) begin
          lex_error();
          return;
        end
        val = accum[30:0];
      end else if (kind == dts_pkg::K_ID && lex_len <= KwLen) begin
        s = "";
        for (int i = 0; i < lex_len; i++) s = {s, string'(kw_text[i])};
        foreach (kw_names[i])
          if (kw_names[i] == s) kind = 6'(kw_kinds[i]);
      end
      emit(0, kind, lex_len[7:0], val);
      clear_lexeme();
    endfunction

    function void note_item(byte unsigned c, bit eot);
      bit [5:0] nx;
      step_out.delete();
      if (halted) begin
        emit(1, 0, 0, 0);
      end else begin
        if (in_comment) begin
          if (c == 8'h0a) in_comment = 0;
        end else if (c == "#") begin
          if (state != dts_pkg::S_START) close_token();
          if (!halted) in_comment = 1;
        end else begin
          for (int p = 0; p < 2 && !halted; p++) begin
            nx = advance_state(state, c);
            if (nx != dts_pkg::S_NONE) begin
              if (lex_len < KwLen) kw_text[lex_len] = c;
              if (lex_len < LenSat) lex_len++;
              if (nx == dts_pkg::K_NUM && !ovf) begin
                if (accum * 10 + (c - "0") > 64'h7fff_ffff) ovf = 1;
                else accum = accum * 10 + (c - "0");
              end
              state = nx;
              break;
            end
            if (state == dts_pkg::S_START) begin
              if (!(c == 8'h20 || c == 8'h0a || c == 8'h09 || c == 8'h0b || c == 8'h0d))
                lex_error();
              break;
            end
            close_token();
          end
        end
        if (!halted && eot && state != dts_pkg::S_START) close_token();
        if (!halted) begin
          if (c == 8'h0a && line != 32'hffff_ffff) line++;
          if (eot) begin
            in_comment = 0;
            line = 1;
          end
        end
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
      pending = {pending, step_out};
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(token_t r);
      token_t e;
      if (pending.size() == 0) begin
        report("unexpected item", r.kind, -1);
        return;
      end
      e = pending.pop_front();
      if (r.status != e.status) report("status", r.status, e.status);
      if (r.kind != e.kind) report("kind", r.kind, e.kind);
      if (r.length != e.length) report("length", r.length, e.length);
      if (r.value != e.value) report("value", r.value, e.value);
      if (r.line != e.line) report("line", r.line, e.line);
      if (r.last != e.last) report("last", r.last, e.last);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  token_scoreboard lexer_sb = new();
  int src_idle;
  int snk_idle;
  int sent;

  dfa_token_scanner_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    token_t r;
    if (!rst && s_tvalid && s_tready) lexer_sb.note_item(s_tdata, s_tlast);
    if (!rst && m_tvalid && m_tready) begin
      r.status = m_tuser;
      r.kind = m_tdata[5:0];
      r.length = m_tdata[13:6];
      r.value = m_tdata[44:14];
      r.line = m_tdata[76:45];
      r.last = m_tlast;
      lexer_sb.check_result(r);
    end
  end

  task automatic send_byte(input byte unsigned b, input bit eot);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eot;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_text(input string s, input bit eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
  endtask

  function automatic string word_text(int n);
    string s;
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(i == 0 ? 52 : 62, 0)])};
    return s;
  endfunction

  // one well-formed lexeme or comment, followed by a separator always after a number, else at random
  task automatic send_lexeme();
    string ops[37] = '{":", "(", ")", ";", "{", "}", ",", "[", "]", "=", "!", ">", "<",
                       "+", "-", "*", "@", "$", "/", "%", "|", "^", "&", "~", ".", "==",
                       "!=", "||", "&&", ">=", ">>", "<=", "<<", "++", "^^", "--", "->"};
    string kws[19] = '{"main", "read", "print", "int", "char", "bool", "struct", "true",
                       "false", "NULL", "return", "if", "elif", "else", "for", "while",
                       "break", "delete", "new"};
    string esc = "\\\"'?ntrba0fv";
    string seps = " \n\t\v\r";
    string s;
    int pick;
    byte unsigned c;
    pick = $urandom_range(99);
    if (pick < 25) s = kws[$urandom_range(18)];
    else if (pick < 45) s = word_text($urandom_range(99) == 0 ? 300 : $urandom_range(9, 1));
    else if (pick < 60)
      s = $sformatf("%0d", $urandom_range(1) ? $urandom_range(999) : $urandom_range(32'h7fffffff));
    else if (pick < 80) s = ops[$urandom_range(36)];
    else if (pick < 90) begin
      if ($urandom_range(1)) s = {"'\\", string'(esc[$urandom_range(11)]), "'"};
      else begin
        do c = $urandom_range(126, 32);
        while (c == 8'h27 || c == 8'h22 || c == "?" || c == 8'h5c || c == "#");
        s = {"'", string'(c), "'"};
      end
    end else begin
      s = "#";
      for (int i = $urandom_range(6); i > 0; i--) begin
        do c = $urandom_range(255); while (c == 8'h0a);
        s = {s, string'(c)};
      end
      s = {s, "\n"};
    end
    send_text(s, $urandom_range(19) == 0);
    if (pick >= 45 && pick < 60 || $urandom_range(1)) send_text(string'(seps[$urandom_range(4)]), 1'b0);
  endtask

  initial begin
    #50ms;
    $display("dfa_token_scanner_unit_tb: errors");
    $finish;
  end

  initial begin
    int pick;
    bit drained;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    src_idle = 0;
    snk_idle = 0;
    sent = 0;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, escapes, two-char operators, comment ending a token
    send_text("_Z9 0 2147483647 'a' '\\n' >>= -> x#", 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("\nif 7", 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 19 : (ph == 1) ? 81 : 0;
      snk_idle = (ph == 0) ? 81 : (ph == 1) ? 19 : 0;
      while (sent < 650 * (ph + 1)) begin
        send_lexeme();
        if (ph == 1 && sent > 1000 && !drained) begin
          drained = 1'b1;
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (lexer_sb.pending.size() != 0) @(posedge clk);
        end
      end
    end

    // scanner halts on the first error, so one error kind per run
    send_text(" ", 1'b0);
    pick = $urandom_range(5);
    case (pick)
      0: send_byte(8'h80 | 8'($urandom_range(127)), 1'b0);
      1: send_text("2147483648 ", 1'b0);
      2: send_text("007 ", 1'b0);
      3: send_text("'ab", 1'b0);
      4: send_text("\"", 1'b0);
      default: send_text("99999999999", 1'b1);
    endcase
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("ok", 1'b0);
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (lexer_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (lexer_sb.errors == 0 && lexer_sb.pending.size() == 0) begin
      $display("dfa_token_scanner_unit_tb: clean");
    end else begin
      $display("dfa_token_scanner_unit_tb: errors");
    end
    $finish;
  end

endmodule
